>>> src/tdpt_pkg.sv
package tdpt_pkg;

  localparam int NUM_BITS_DEF = 16;
  localparam int COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
  localparam logic [COUNT_W-1:0] PRIME_COUNT = 8'd2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_DIV   = 3'b100
  } state_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_status_t;

endpackage

>>> src/tdpt_div.sv
module tdpt_div import tdpt_pkg::*; #(
  parameter int NUM_BITS = NUM_BITS_DEF,
  parameter int DW = (NUM_BITS + 1) / 2 + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] dividend,
  input  logic [DW-1:0]       divisor,
  output div_status_t         status
);

  localparam int CW = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

  logic                running;
  logic [CW-1:0]       cnt;
  logic [NUM_BITS-1:0] shreg;
  logic [DW-1:0]       rem;
  logic [DW-1:0]       dsr;
  logic [DW:0]         trial;
  logic [DW-1:0]       rem_next;

  // One restoring step: bring down the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {rem, shreg[NUM_BITS-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = DW'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt <= '0;
      status <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt <= CW'(NUM_BITS - 1);
      end else if (running) begin
        cnt <= cnt - CW'(1);
        if (cnt == '0) begin
          running <= 1'b0;
          status.done <= 1'b1;
          status.rem_zero <= (rem_next == '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (running) begin
      shreg <= {shreg[NUM_BITS-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

>>> src/trial_division_prime_test.sv
// Channel   Ports                        Handshake
// input     number                       taken when start is high and busy is low
// result    is_prime, divisor_count      valid for the one cycle that done is high
//
// Each item steps a trial divisor d from 1 while d*d <= number, and every trial
// runs through the shared bit-serial remainder unit, one dividend bit at a time;
// for 0 no trial runs and the result comes from the first check.
// Reset returns the sequencer to idle and drops done. busy stays high until the
// result cycle; the receiver cannot stall, so a result is never held.
module trial_division_prime_test import tdpt_pkg::*; #(
  parameter int NUM_BITS = NUM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [NUM_BITS-1:0] number,
  output logic                done,
  output logic                is_prime,
  output logic [COUNT_W-1:0]  divisor_count
);

  localparam int DW = (NUM_BITS + 1) / 2 + 1;
  localparam int SW = 2 * DW;

  state_t              state;
  logic [NUM_BITS-1:0] n;
  logic [DW-1:0]       d;
  logic [SW-1:0]       sq;
  logic [COUNT_W-1:0]  cnt;
  logic                div_start;
  div_status_t         div_st;
  logic                sq_le_n;
  logic [COUNT_W:0]    cnt_sum;
  logic [COUNT_W-1:0]  cnt_next;

  assign busy = (state != ST_IDLE);
  assign sq_le_n = (sq <= SW'(n));
  assign div_start = (state == ST_CHECK) && sq_le_n;

  // A divisor equal to the square root counts once, any other pairs with n/d.
  always_comb begin
    if (sq == SW'(n)) begin
      cnt_sum = {1'b0, cnt} + (COUNT_W + 1)'(1);
    end else begin
      cnt_sum = {1'b0, cnt} + (COUNT_W + 1)'(2);
    end
    if (cnt_sum > {1'b0, COUNT_MAX}) begin
      cnt_next = COUNT_MAX;
    end else begin
      cnt_next = cnt_sum[COUNT_W-1:0];
    end
  end

  tdpt_div #(
    .NUM_BITS(NUM_BITS),
    .DW(DW)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(n),
    .divisor(d),
    .status(div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (sq_le_n) begin
            state <= ST_DIV;
          end else begin
            state <= ST_IDLE;
            done <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_st.done) begin
            state <= ST_CHECK;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          n <= number;
          d <= DW'(1);
          sq <= SW'(1);
          cnt <= '0;
        end
      end
      ST_CHECK: begin
        if (!sq_le_n) begin
          is_prime <= (cnt == PRIME_COUNT);
          divisor_count <= cnt;
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          if (div_st.rem_zero) begin
            cnt <= cnt_next;
          end
          d <= d + DW'(1);
          sq <= sq + {{(SW - DW - 1){1'b0}}, d, 1'b0} + SW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
